[rtl/core/feeu_pkg.sv]
package feeu_pkg;

   // Default image size in bytes
   localparam int IMAGE_BYTES_DEF = 1024;

   // Number of flash page slots in the sector
   localparam logic [31:0] PAGE_SLOTS = 32'd128;

   // Width of one memory row: four image bytes
   localparam int ROW_BITS = 32;

   typedef enum logic [2:0] {
      CMD_READ_BYTE  = 3'd0,
      CMD_WRITE_BYTE = 3'd1,
      CMD_FLUSH      = 3'd2,
      CMD_READ_WORD  = 3'd3,
      CMD_LOAD_WORD  = 3'd4,
      CMD_SET_SLOT   = 3'd5
   } cmd_type;

   // One accepted request
   typedef struct packed {
      cmd_type      command;
      logic [9:0]   byte_address;
      logic [7:0]   byte_value;
      logic [7:0]   word_index;
      logic [31:0]  flash_word;
      logic [6:0]   slot_number;
   } req_type;

   // One result, shown for a single cycle
   typedef struct packed {
      logic         strobe;
      logic [7:0]   read_byte;
      logic [31:0]  program_word;
      logic         erase_request;
      logic         program_request;
      logic [6:0]   page_slot;
   } rsp_type;

   // Memory row touched by a request
   function automatic logic [31:0] row_of(cmd_type cmd, logic [9:0] addr, logic [7:0] widx);
      logic [31:0] row;
      case (cmd)
         CMD_READ_WORD, CMD_LOAD_WORD: row = {24'b0, widx};
         default:                      row = {24'b0, addr[9:2]};
      endcase
      return row;
   endfunction

endpackage

[rtl/core/feeu_ram.sv]
module feeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/feeu_clear.sv]
module feeu_clear #(
   parameter int ROWS = 256,
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   output logic          clear_active,
   output logic [RW-1:0] clear_row
);

   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   logic          active_ff;
   logic [RW-1:0] row_ff;

   // Sweep every row once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         row_ff    <= '0;
      end else if (active_ff) begin
         row_ff <= row_ff + RW'(1);
         if (row_ff == LAST_ROW) begin
            active_ff <= 1'b0;
         end
      end
   end

   assign clear_active = active_ff;
   assign clear_row    = row_ff;

endmodule

[rtl/core/feeu_exec.sv]
module feeu_exec import feeu_pkg::*; #(
   parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
   localparam int ROWS = (IMAGE_BYTES + 3) / 4,
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_type             req,
   input  logic [ROW_BITS-1:0] rd_data,
   output logic                exec_active,
   output logic                wr_en,
   output logic [RW-1:0]       wr_row,
   output logic [ROW_BITS-1:0] wr_data,
   output rsp_type             rsp
);

   localparam logic [31:0] IMAGE_LIMIT = 32'(IMAGE_BYTES);

   req_type     req_ff;
   logic        exec_ff;
   logic        dirty_ff, dirty_in;
   logic        new_page_ff, new_page_in;
   logic [6:0]  slot_ff, slot_in;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] row_full;
   logic [1:0]  lane;
   logic        byte_ok;
   logic [3:0]  word_ok;
   logic [7:0]  old_byte;
   logic [7:0]  new_byte;
   logic [31:0] word_base;
   logic [31:0] word_gather;
   logic [31:0] word_merge;
   logic [31:0] byte_merge;
   logic [7:0]  slot_next;

   // Hold the request for the execute cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff <= 1'b0;
      end else begin
         exec_ff <= accept;
      end
      if (accept) begin
         req_ff <= req;
      end
   end

   assign row_full = row_of(req_ff.command, req_ff.byte_address, req_ff.word_index);
   assign wr_row   = row_full[RW-1:0];

   // Byte lane view of the row read from memory
   always_comb begin
      lane      = req_ff.byte_address[1:0];
      byte_ok   = {22'b0, req_ff.byte_address} < IMAGE_LIMIT;
      old_byte  = rd_data[{lane, 3'b000} +: 8];
      new_byte  = req_ff.byte_value;
      word_base = {22'b0, req_ff.word_index, 2'b00};
      byte_merge = rd_data;
      byte_merge[{lane, 3'b000} +: 8] = new_byte;
      for (int k = 0; k < 4; k++) begin
         word_ok[k] = (word_base + 32'(k)) < IMAGE_LIMIT;
         word_gather[8*k +: 8] = word_ok[k] ? rd_data[8*k +: 8] : 8'h00;
         word_merge[8*k +: 8]  = word_ok[k] ? ~req_ff.flash_word[8*k +: 8]
                                            : rd_data[8*k +: 8];
      end
      slot_next = {1'b0, slot_ff} + {7'b0, new_page_ff};
   end

   // Execute the command: modify the row, update flags and slot
   always_comb begin
      dirty_in    = dirty_ff;
      new_page_in = new_page_ff;
      slot_in     = slot_ff;
      wr_en       = 1'b0;
      wr_data     = rd_data;
      rsp_in      = '0;
      rsp_in.strobe = exec_ff;
      if (exec_ff) begin
         case (req_ff.command)
            CMD_READ_BYTE: begin
               rsp_in.read_byte = byte_ok ? old_byte : 8'h00;
            end
            CMD_WRITE_BYTE: begin
               if (byte_ok) begin
                  wr_en   = 1'b1;
                  wr_data = byte_merge;
                  if (old_byte != new_byte) begin
                     dirty_in = 1'b1;
                     if (((old_byte ^ new_byte) & ~new_byte) != 8'h00) begin
                        new_page_in = 1'b1;
                     end
                  end
               end
            end
            CMD_FLUSH: begin
               if (dirty_ff || new_page_ff) begin
                  rsp_in.program_request = 1'b1;
                  dirty_in    = 1'b0;
                  new_page_in = 1'b0;
                  if ({24'b0, slot_next} >= PAGE_SLOTS) begin
                     rsp_in.erase_request = 1'b1;
                     slot_in = 7'd0;
                  end else begin
                     slot_in = slot_next[6:0];
                  end
               end
            end
            CMD_READ_WORD: begin
               rsp_in.program_word = ~word_gather;
            end
            CMD_LOAD_WORD: begin
               wr_en   = |word_ok;
               wr_data = word_merge;
            end
            CMD_SET_SLOT: begin
               slot_in     = req_ff.slot_number;
               dirty_in    = 1'b0;
               new_page_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.page_slot = slot_in;
   end

   // Flags, slot and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff      <= 1'b0;
         new_page_ff   <= 1'b0;
         slot_ff       <= 7'd0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         dirty_ff      <= dirty_in;
         new_page_ff   <= new_page_in;
         slot_ff       <= slot_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
      rsp_ff.read_byte       <= rsp_in.read_byte;
      rsp_ff.program_word    <= rsp_in.program_word;
      rsp_ff.erase_request   <= rsp_in.erase_request;
      rsp_ff.program_request <= rsp_in.program_request;
      rsp_ff.page_slot       <= rsp_in.page_slot;
   end

   assign exec_active = exec_ff;
   assign rsp         = rsp_ff;

endmodule

[rtl/core/flash_eeprom_emulation_unit.sv]
// For each request the memory row is read at the accepting edge,
// modified and written back in the next cycle, and busy is high for that cycle.
// No new request is accepted until the read-modify-write of that one row is done.
// The result strobe is high in the cycle after execute; the receiver cannot stall.
// After reset a clearing pass zeroes the image, one row a cycle, over all
// ceil(IMAGE_BYTES/4) rows (256 at the default size) with busy held high.
module flash_eeprom_emulation_unit import feeu_pkg::*; #(
   parameter int IMAGE_BYTES = IMAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [9:0]  req_byte_address,
   input  logic [7:0]  req_byte_value,
   input  logic [7:0]  req_word_index,
   input  logic [31:0] req_flash_word,
   input  logic [6:0]  req_slot_number,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_byte,
   output logic [31:0] rsp_program_word,
   output logic        rsp_erase_request,
   output logic        rsp_program_request,
   output logic [6:0]  rsp_page_slot
);

   localparam int ROWS = (IMAGE_BYTES + 3) / 4;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic                accept;
   req_type             req;
   rsp_type             rsp;
   logic                clear_active;
   logic [RW-1:0]       clear_row;
   logic                exec_active;
   logic                exec_wr_en;
   logic [RW-1:0]       exec_wr_row;
   logic [ROW_BITS-1:0] exec_wr_data;
   logic [31:0]         rd_row_full;
   logic                ram_wr_en;
   logic [RW-1:0]       ram_wr_addr;
   logic [ROW_BITS-1:0] ram_wr_data;
   logic [ROW_BITS-1:0] ram_rd_data;

   assign busy   = clear_active | exec_active;
   assign accept = start & ~busy;

   // Pack the request ports
   always_comb begin
      req.command      = cmd_type'(req_command);
      req.byte_address = req_byte_address;
      req.byte_value   = req_byte_value;
      req.word_index   = req_word_index;
      req.flash_word   = req_flash_word;
      req.slot_number  = req_slot_number;
   end

   assign rd_row_full = row_of(req.command, req_byte_address, req_word_index);

   // Clearing pass owns the write port until it ends
   assign ram_wr_en   = clear_active | exec_wr_en;
   assign ram_wr_addr = clear_active ? clear_row : exec_wr_row;
   assign ram_wr_data = clear_active ? '0 : exec_wr_data;

   feeu_clear #(
      .ROWS (ROWS)
   ) u_clear (
      .clock        (clock),
      .reset        (reset),
      .clear_active (clear_active),
      .clear_row    (clear_row)
   );

   feeu_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_row_full[RW-1:0]),
      .rd_data (ram_rd_data)
   );

   feeu_exec #(
      .IMAGE_BYTES (IMAGE_BYTES)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req),
      .rd_data     (ram_rd_data),
      .exec_active (exec_active),
      .wr_en       (exec_wr_en),
      .wr_row      (exec_wr_row),
      .wr_data     (exec_wr_data),
      .rsp         (rsp)
   );

   // Drive the result ports
   assign rsp_strobe          = rsp.strobe;
   assign rsp_read_byte       = rsp.read_byte;
   assign rsp_program_word    = rsp.program_word;
   assign rsp_erase_request   = rsp.erase_request;
   assign rsp_program_request = rsp.program_request;
   assign rsp_page_slot       = rsp.page_slot;

endmodule
